>>> rtl/wobf_pkg.sv
// wobf_pkg: shared types, register codes and key tables for the word obfuscation cipher
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package wobf_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_TABLE_SEL = 2'd1;

  // transform direction
  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  // per-byte constant part of the key: 0xa5 | (k << k) | k
  localparam logic [7:0] KEY_BASE [4] = '{8'hA5, 8'hA7, 8'hAF, 8'hBF};

  // built-in key tables
  localparam logic [7:0] KEY_TABLE [3][16] = '{
    '{8'h7A, 8'h64, 8'h05, 8'hF1, 8'h1B, 8'h9B, 8'hA0, 8'hB5,
      8'hCA, 8'hED, 8'h61, 8'h0D, 8'h4A, 8'hDF, 8'h8E, 8'hC7},
    '{8'h05, 8'h61, 8'h7A, 8'hED, 8'h1B, 8'hCA, 8'h0D, 8'h9B,
      8'h4A, 8'hF1, 8'h64, 8'hC7, 8'hB5, 8'h8E, 8'hDF, 8'hA0},
    '{8'h20, 8'h07, 8'h13, 8'h61, 8'h03, 8'h45, 8'h17, 8'h72,
      8'h0A, 8'h2D, 8'h48, 8'h0C, 8'h4A, 8'h12, 8'hA9, 8'hB5}
  };

  // one classified word waiting in the queue
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] seq;
    logic [31:0] key;
    dir_t        dir;
  } q_entry_t;

  // front to queue write request
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // key word for a table selector and word index; selector three acts as table two
  function automatic logic [31:0] key_word(input logic [1:0] sel, input logic [3:0] idx);
    logic [1:0]  t;
    logic [3:0]  j;
    logic [31:0] w;
    t = (sel > 2'd2) ? 2'd2 : sel;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      j = idx + 4'(k);
      w[8*k +: 8] = KEY_BASE[k] | KEY_TABLE[t][j];
    end
    return w;
  endfunction

endpackage

>>> rtl/wobf_front.sv
// wobf_front: input side; holds configuration, word counter and key generation
// depends on wobf_pkg
`timescale 1ns / 1ps

module wobf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,
  input  logic               in_tlast,
  input  wobf_pkg::q_stat_t  q_stat,
  output wobf_pkg::q_push_t  q_push
);

  wobf_pkg::dir_t direction_r;
  logic [1:0]     table_sel_r;
  logic [3:0]     word_index_r;
  logic [3:0]     word_index_nxt;
  logic           accept;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= wobf_pkg::DIR_ENCODE;
      table_sel_r <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wobf_pkg::REG_DIRECTION: direction_r <= wobf_pkg::dir_t'(cfg_wdata[0]);
        wobf_pkg::REG_TABLE_SEL: table_sel_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // accept whenever the queue has room
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // word counter, back to zero after the last word of a message
  always_comb begin
    word_index_nxt = word_index_r;
    if (accept) begin
      word_index_nxt = in_tlast ? 4'd0 : word_index_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r <= 4'd0;
    end else begin
      word_index_r <= word_index_nxt;
    end
  end

  // classified word into the queue
  always_comb begin
    q_push.push        = accept;
    q_push.entry.word  = in_tdata[31:0];
    q_push.entry.seq   = in_tdata[63:32];
    q_push.entry.key   = wobf_pkg::key_word(table_sel_r, word_index_r);
    q_push.entry.dir   = direction_r;
  end

endmodule

>>> rtl/wobf_queue.sv
// wobf_queue: short register queue between front and back
// depends on wobf_pkg
`timescale 1ns / 1ps

module wobf_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wobf_pkg::q_push_t  q_push,
  input  logic               pop,
  output wobf_pkg::q_entry_t head,
  output wobf_pkg::q_stat_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wobf_pkg::q_entry_t slot_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  // status
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (q_push.push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!q_push.push && pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slot_r[wr_ptr_r] <= q_push.entry;
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> !q_stat.full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push.push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not follow a write");

endmodule

>>> rtl/wobf_back.sv
// wobf_back: output side; applies the xor, byte swap and key mix to the queue head
// depends on wobf_pkg
`timescale 1ns / 1ps

module wobf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wobf_pkg::q_entry_t head,
  input  wobf_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r;
  logic [31:0] result;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // word transform for either direction
  always_comb begin
    unique case (head.dir)
      wobf_pkg::DIR_ENCODE: result = swap_bytes(head.word ^ ~head.seq) ^ head.key ^ head.seq;
      wobf_pkg::DIR_DECODE: result = swap_bytes(head.word ^ head.seq ^ head.key) ^ ~head.seq;
      default:              result = head.word;
    endcase
  end

  // take the head when the output register is free or being drained
  assign pop = !q_stat.empty && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output data register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

endmodule

>>> rtl/word_obfuscation_cipher.sv
// word_obfuscation_cipher: top level; front, queue and back of the word cipher
// path: an accepted word is written to a queue slot, then taken into the output register behind out_tvalid
// throughput: one word per cycle while out_tready is high; the back refills its output register as it drains
// reset: synchronous active-low rst_n clears configuration, word counter, queue
// pointers and output valid; depends on wobf_pkg, wobf_front, wobf_queue, wobf_back
`timescale 1ns / 1ps

module word_obfuscation_cipher #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // in_word [31:0], seq_value [63:32]
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // out_word [31:0]
);

  wobf_pkg::q_push_t  q_push;
  wobf_pkg::q_stat_t  q_stat;
  wobf_pkg::q_entry_t head;
  logic               pop;

  // word intake and key generation
  wobf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push)
  );

  // decoupling queue
  wobf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // transform and output register
  wobf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
